[hdl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/mfrq_pkg.sv]
// types, constants and codes of the matrix flip and rotate engine
`timescale 1ns / 1ps

package mfrq_pkg;

	// geometry and storage
	localparam int MAX_DIM    = 128;
	localparam int VALUE_BITS = 32;
	localparam int DIM_W      = 8;
	localparam int IDX_W      = $clog2(MAX_DIM);
	localparam int CELLS      = MAX_DIM * MAX_DIM;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int CFG_IDX_W  = 2;
	localparam int POS_W      = 7;

	// register reset: 128, or the largest even value not above the maximum
	localparam logic [DIM_W-1:0] REG_RESET = (MAX_DIM >= 128) ? DIM_W'(128) :
		DIM_W'(MAX_DIM & ~1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

	// operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_XFORM = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// transform codes
	localparam logic [2:0] XF_VFLIP = 3'd1;
	localparam logic [2:0] XF_HFLIP = 3'd2;
	localparam logic [2:0] XF_ROTCW = 3'd3;
	localparam logic [2:0] XF_ROTCC = 3'd4;
	localparam logic [2:0] XF_QUADC = 3'd5;
	localparam logic [2:0] XF_QUADA = 3'd6;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
		logic [2:0]         transform;
	} in_req_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
		logic               last;
	} out_rsp_t;

	// memory requests issued by the transform sequencer
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
	} walk_mem_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIM_W-1:0] new_rows;
		logic [DIM_W-1:0] new_cols;
	} walk_stat_t;

endpackage

[hdl/mfrq_ram.sv]
// simple dual port ram with registered read data
`timescale 1ns / 1ps

module mfrq_ram #(
	parameter int ADDR_BITS = 14,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
	logic [DATA_BITS-1:0] rdata_q;

	// one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/mfrq_walk.sv]
// transform sequencer: walks the source bank and computes destination addresses
`timescale 1ns / 1ps

module mfrq_walk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2:0]                   code,
	input  logic [mfrq_pkg::DIM_W-1:0]   n,
	input  logic [mfrq_pkg::DIM_W-1:0]   m,
	output mfrq_pkg::walk_mem_t          mem,
	output mfrq_pkg::walk_stat_t         stat
);

	typedef enum logic [1:0] {
		W_IDLE,
		W_RUN,
		W_DRAIN
	} wstate_t;

	wstate_t                         state_q;
	logic [2:0]                      code_q;
	logic [mfrq_pkg::DIM_W-1:0]      n_q;
	logic [mfrq_pkg::DIM_W-1:0]      m_q;
	logic [mfrq_pkg::DIM_W-1:0]      nc_q;
	logic [mfrq_pkg::IDX_W-1:0]      i_q;
	logic [mfrq_pkg::IDX_W-1:0]      j_q;
	logic [mfrq_pkg::ADDR_W-1:0]     src_q;
	logic                            v_s1;
	logic [mfrq_pkg::IDX_W-1:0]      di_s1;
	logic [mfrq_pkg::IDX_W-1:0]      dj_s1;

	logic [mfrq_pkg::DIM_W-1:0]      iw, jw, hh, ww, di_w, dj_w;
	logic                            top_w, left_w, rot_w;
	logic                            j_end, i_end;
	logic [mfrq_pkg::IDX_W+mfrq_pkg::DIM_W-1:0] dst_w;

	// destination coordinates of the current source element
	always_comb begin
		iw     = (mfrq_pkg::DIM_W)'(i_q);
		jw     = (mfrq_pkg::DIM_W)'(j_q);
		hh     = n_q >> 1;
		ww     = m_q >> 1;
		top_w  = iw < hh;
		left_w = jw < ww;
		di_w   = iw;
		dj_w   = jw;
		case (code_q)
			mfrq_pkg::XF_VFLIP: begin
				di_w = n_q - 1'b1 - iw;
			end
			mfrq_pkg::XF_HFLIP: begin
				dj_w = m_q - 1'b1 - jw;
			end
			mfrq_pkg::XF_ROTCW: begin
				di_w = jw;
				dj_w = n_q - 1'b1 - iw;
			end
			mfrq_pkg::XF_ROTCC: begin
				di_w = m_q - 1'b1 - jw;
				dj_w = iw;
			end
			mfrq_pkg::XF_QUADC: begin
				if (top_w && left_w) dj_w = jw + ww;
				else if (top_w) di_w = iw + hh;
				else if (!left_w) dj_w = jw - ww;
				else di_w = iw - hh;
			end
			mfrq_pkg::XF_QUADA: begin
				if (top_w && left_w) di_w = iw + hh;
				else if (top_w) dj_w = jw - ww;
				else if (!left_w) di_w = iw - hh;
				else dj_w = jw + ww;
			end
			default: begin
				di_w = iw;
				dj_w = jw;
			end
		endcase
	end

	assign j_end = jw == (m_q - 1'b1);
	assign i_end = iw == (n_q - 1'b1);
	assign rot_w = (code == mfrq_pkg::XF_ROTCW) || (code == mfrq_pkg::XF_ROTCC);

	// state, walk counters and the address stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			v_s1    <= 1'b0;
		end else begin
			case (state_q)
				W_IDLE: begin
					v_s1 <= 1'b0;
					if (start) begin
						code_q  <= code;
						n_q     <= n;
						m_q     <= m;
						nc_q    <= rot_w ? n : m;
						i_q     <= '0;
						j_q     <= '0;
						src_q   <= '0;
						state_q <= W_RUN;
					end
				end
				W_RUN: begin
					v_s1  <= 1'b1;
					di_s1 <= (mfrq_pkg::IDX_W)'(di_w);
					dj_s1 <= (mfrq_pkg::IDX_W)'(dj_w);
					src_q <= src_q + 1'b1;
					if (j_end) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_end) begin
							state_q <= W_DRAIN;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				W_DRAIN: begin
					v_s1    <= 1'b0;
					state_q <= W_IDLE;
				end
				default: begin
					v_s1    <= 1'b0;
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	// destination address, written with the data read in the cycle before
	assign dst_w = (mfrq_pkg::IDX_W+mfrq_pkg::DIM_W)'(di_s1) *
		(mfrq_pkg::IDX_W+mfrq_pkg::DIM_W)'(nc_q) +
		(mfrq_pkg::IDX_W+mfrq_pkg::DIM_W)'(dj_s1);

	assign mem.rd_en   = state_q == W_RUN;
	assign mem.rd_addr = src_q;
	assign mem.wr_en   = v_s1;
	assign mem.wr_addr = dst_w[mfrq_pkg::ADDR_W-1:0];

	assign stat.busy     = state_q != W_IDLE;
	assign stat.done     = state_q == W_DRAIN;
	assign stat.new_rows = ((code_q == mfrq_pkg::XF_ROTCW) || (code_q == mfrq_pkg::XF_ROTCC))
		? m_q : n_q;
	assign stat.new_cols = nc_q;

endmodule

[hdl/matrix_flip_rotate_quadrant.sv]
// top level of the matrix flip, rotate and quadrant move engine
//
//  channel   direction  handshake               payload
//  in        request    in_valid / in_ready     in_req  (op, value, transform)
//  out       response   out_valid / out_ready   out_rsp (value_res, row, col, last)
//  cfg       write      cfg_we                  cfg_index, cfg_data
//
// loads and reads are taken one a cycle unless a transform runs or the output stalls;
// a read response passes the bank read register and then the output register
// the sequencer streams the source bank through its single read port into the other
// bank, one element a cycle; no input request is taken while a transform runs
// reset clears control state only; both banks hold no data until loaded
// a stalled output holds one response plus one read in flight, then input stalls
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_flip_rotate_quadrant (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mfrq_pkg::in_req_t                 in_req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mfrq_pkg::out_rsp_t                out_rsp,
	input  logic                              cfg_we,
	input  logic [mfrq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mfrq_pkg::DIM_W-1:0]        cfg_data
);

	logic [mfrq_pkg::DIM_W-1:0]      reg_rows_q, reg_cols_q;
	logic [mfrq_pkg::DIM_W-1:0]      cur_rows_q, cur_cols_q;
	logic                            active_q;
	logic [mfrq_pkg::ADDR_W:0]       load_pos_q;
	logic [mfrq_pkg::ADDR_W-1:0]     read_pos_q;
	logic [mfrq_pkg::IDX_W-1:0]      row_q, col_q;

	logic                            rd_s1;
	logic [mfrq_pkg::IDX_W-1:0]      row_s1, col_s1;
	logic                            last_s1;
	logic                            out_valid_q;
	mfrq_pkg::out_rsp_t              out_rsp_q;

	logic [2*mfrq_pkg::DIM_W-1:0]    total;
	logic                            accept, is_load, is_xf, is_read, xf_ok;
	logic                            load_wr, load_room, out_load, last_w;
	logic                            cfg_ok;
	logic                            a_we, b_we, a_re, b_re;
	logic [mfrq_pkg::ADDR_W-1:0]     a_waddr, b_waddr, raddr;
	logic [mfrq_pkg::VALUE_BITS-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
	logic [mfrq_pkg::VALUE_BITS-1:0] src_rdata, load_data;

	mfrq_pkg::walk_mem_t             walk_mem;
	mfrq_pkg::walk_stat_t            walk_st;

	// request decode
	assign total     = (2*mfrq_pkg::DIM_W)'(cur_rows_q) * (2*mfrq_pkg::DIM_W)'(cur_cols_q);
	assign out_load  = rd_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !walk_st.busy && (!rd_s1 || out_load);
	assign accept    = in_valid && in_ready;
	assign is_load   = accept && (in_req.op == mfrq_pkg::OP_LOAD);
	assign is_xf     = accept && (in_req.op == mfrq_pkg::OP_XFORM);
	assign is_read   = accept && (in_req.op == mfrq_pkg::OP_READ);
	assign xf_ok     = (in_req.transform >= mfrq_pkg::XF_VFLIP) &&
		(in_req.transform <= mfrq_pkg::XF_QUADA);
	assign load_room = (2*mfrq_pkg::DIM_W)'(load_pos_q) < total;
	assign load_wr   = is_load && load_room;
	assign last_w    = ((mfrq_pkg::DIM_W)'(row_q) == cur_rows_q - 1'b1) &&
		((mfrq_pkg::DIM_W)'(col_q) == cur_cols_q - 1'b1);
	assign load_data = (mfrq_pkg::VALUE_BITS)'(in_req.value);

	// valid register write: even, in range, one of the two indexes
	assign cfg_ok = cfg_we && !cfg_data[0] && (cfg_data >= 2) &&
		(cfg_data <= (mfrq_pkg::DIM_W)'(mfrq_pkg::MAX_DIM)) &&
		((cfg_index == mfrq_pkg::CFG_ROWS) || (cfg_index == mfrq_pkg::CFG_COLS));

	// transform sequencer
	mfrq_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (is_xf && xf_ok),
		.code   (in_req.transform),
		.n      (cur_rows_q),
		.m      (cur_cols_q),
		.mem    (walk_mem),
		.stat   (walk_st)
	);

	// bank port steering: loads and reads use the active bank, transforms write the other
	assign src_rdata = active_q ? b_rdata : a_rdata;
	assign raddr     = walk_st.busy ? walk_mem.rd_addr : read_pos_q;
	assign a_re      = !active_q && (is_read || walk_mem.rd_en);
	assign b_re      = active_q && (is_read || walk_mem.rd_en);
	assign a_we      = active_q ? walk_mem.wr_en : load_wr;
	assign b_we      = active_q ? load_wr : walk_mem.wr_en;
	assign a_waddr   = active_q ? walk_mem.wr_addr : load_pos_q[mfrq_pkg::ADDR_W-1:0];
	assign b_waddr   = active_q ? load_pos_q[mfrq_pkg::ADDR_W-1:0] : walk_mem.wr_addr;
	assign a_wdata   = active_q ? src_rdata : load_data;
	assign b_wdata   = active_q ? load_data : src_rdata;

	mfrq_ram #(
		.ADDR_BITS (mfrq_pkg::ADDR_W),
		.DATA_BITS (mfrq_pkg::VALUE_BITS)
	) u_bank_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (a_re),
		.raddr (raddr),
		.rdata (a_rdata)
	);

	mfrq_ram #(
		.ADDR_BITS (mfrq_pkg::ADDR_W),
		.DATA_BITS (mfrq_pkg::VALUE_BITS)
	) u_bank_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (raddr),
		.rdata (b_rdata)
	);

	// shape, bank select and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_rows_q <= mfrq_pkg::REG_RESET;
			reg_cols_q <= mfrq_pkg::REG_RESET;
			cur_rows_q <= mfrq_pkg::REG_RESET;
			cur_cols_q <= mfrq_pkg::REG_RESET;
			active_q   <= 1'b0;
			load_pos_q <= '0;
			read_pos_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else if (cfg_ok) begin
			if (cfg_index == mfrq_pkg::CFG_ROWS) begin
				reg_rows_q <= cfg_data;
				cur_rows_q <= cfg_data;
				cur_cols_q <= reg_cols_q;
			end else begin
				reg_cols_q <= cfg_data;
				cur_rows_q <= reg_rows_q;
				cur_cols_q <= cfg_data;
			end
			load_pos_q <= '0;
			read_pos_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else begin
			if (load_wr) begin
				load_pos_q <= load_pos_q + 1'b1;
			end
			if (is_load || walk_st.done) begin
				read_pos_q <= '0;
				row_q      <= '0;
				col_q      <= '0;
			end
			if (walk_st.done) begin
				cur_rows_q <= walk_st.new_rows;
				cur_cols_q <= walk_st.new_cols;
				active_q   <= !active_q;
			end
			// read pointer walks row-major and wraps after the last element
			if (is_read) begin
				if (last_w) begin
					read_pos_q <= '0;
					row_q      <= '0;
					col_q      <= '0;
				end else if ((mfrq_pkg::DIM_W)'(col_q) == cur_cols_q - 1'b1) begin
					read_pos_q <= read_pos_q + 1'b1;
					row_q      <= row_q + 1'b1;
					col_q      <= '0;
				end else begin
					read_pos_q <= read_pos_q + 1'b1;
					col_q      <= col_q + 1'b1;
				end
			end
		end
	end

	// read in flight while the bank delivers data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else if (is_read) begin
			rd_s1 <= 1'b1;
		end else if (out_load) begin
			rd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_read) begin
			row_s1  <= row_q;
			col_s1  <= col_q;
			last_s1 <= last_w;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rsp_q.value_res <= 32'($signed(src_rdata));
			out_rsp_q.row       <= (mfrq_pkg::POS_W)'(row_s1);
			out_rsp_q.col       <= (mfrq_pkg::POS_W)'(col_s1);
			out_rsp_q.last      <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// checks
	`ASSERT_NEVER(a_no_req_in_xform, clk, arst_n, walk_st.busy && in_ready, "request taken during transform")
	`ASSERT_IMPL(a_read_kept, clk, arst_n, rd_s1 && out_valid_q && !out_ready |=> rd_s1, "pending read lost")
	`ASSERT_NEVER(a_load_bound, clk, arst_n, (2*mfrq_pkg::DIM_W)'(load_pos_q) > total, "load pointer past matrix")
	`ASSERT_NEVER(a_read_bound, clk, arst_n, (2*mfrq_pkg::DIM_W)'(read_pos_q) >= total, "read pointer past matrix")

endmodule
